### rtl/wrqi_pkg.sv
// ----------------------------------------------------------------------------
// wrqi_pkg
// Shared constants and control types for the windowed repeat-ID qualifier.
// ----------------------------------------------------------------------------
package wrqi_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ID_BITS     = 32;
  localparam int TIME_W      = 32;
  localparam int MIN_W       = 5;
  localparam int CNT_W       = 5;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 1;

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_IW = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_MAX = (1 << CNT_W) - 1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_REPEATS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = CFG_IDX_W'(1);

  typedef struct packed {
    logic load_item;
    logic age_step;
    logic insert;
    logic remove_step;
    logic load_out;
  } wrqi_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic hit;
  } wrqi_status_t;

endpackage

### rtl/windowed_repeat_id_qualifier.sv
// ----------------------------------------------------------------------------
// windowed_repeat_id_qualifier
// Counts recent sightings of a device ID in a sliding time window and accepts
// the ID once it has been seen often enough.
// ----------------------------------------------------------------------------
// One request at a time. A request runs from acceptance to a loaded result
// through one age-and-match scan of the 16-entry slot table, one entry per
// cycle, then the insert step and the output load. When the ID is accepted, a
// second scan before the output load removes that ID's entries. A new
// request is taken once the result has moved to the output register, so a
// waiting result does not block the next request. The slot table is empty
// after reset.
module windowed_repeat_id_qualifier
  import wrqi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ID_BITS-1:0]   device_id,
  input  logic [TIME_W-1:0]    arrival_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 accepted,
  output logic [CNT_W-1:0]     match_count,
  output logic                 evicted_oldest
);

  wrqi_cmd_t    cmd;
  wrqi_status_t status;

  wrqi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  wrqi_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .device_id      (device_id),
    .arrival_time   (arrival_time),
    .cmd            (cmd),
    .status         (status),
    .accepted       (accepted),
    .match_count    (match_count),
    .evicted_oldest (evicted_oldest)
  );

endmodule

### rtl/wrqi_ctrl.sv
// ----------------------------------------------------------------------------
// wrqi_ctrl
// Sequencer for one request: age pass, insert, optional removal pass, result.
// ----------------------------------------------------------------------------
module wrqi_ctrl
  import wrqi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  wrqi_status_t status,
  output wrqi_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_AGE    = 5'b00010,
    S_INSERT = 5'b00100,
    S_REMOVE = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_AGE;
        end
      end
      S_AGE: begin
        cmd.age_step = 1'b1;
        if (status.idx_last) state_next = S_INSERT;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = status.hit ? S_REMOVE : S_FINISH;
      end
      S_REMOVE: begin
        cmd.remove_step = 1'b1;
        if (status.idx_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### rtl/wrqi_dp.sv
// ----------------------------------------------------------------------------
// wrqi_dp
// Slot table, configuration registers, scan index and result registers.
// ----------------------------------------------------------------------------
module wrqi_dp
  import wrqi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [ID_BITS-1:0]   device_id,
  input  logic [TIME_W-1:0]    arrival_time,
  input  wrqi_cmd_t            cmd,
  output wrqi_status_t         status,
  output logic                 accepted,
  output logic [CNT_W-1:0]     match_count,
  output logic                 evicted_oldest
);

  logic [MIN_W-1:0]       min_repeats;
  logic [TIME_W-1:0]      window_ticks;

  logic [TABLE_DEPTH-1:0] slot_valid;
  logic [ID_BITS-1:0]     slot_id   [TABLE_DEPTH];
  logic [TIME_W-1:0]      slot_time [TABLE_DEPTH];

  logic [ID_BITS-1:0]     cur_id;
  logic [TIME_W-1:0]      cur_time;
  logic [IDX_W-1:0]       idx;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic                   old_found;
  logic [IDX_W-1:0]       old_idx;
  logic [TIME_W-1:0]      old_age;
  logic                   old_match;
  logic [CNT_IW-1:0]      surv_count;
  logic [CNT_IW-1:0]      res_count;
  logic                   res_evict;

  logic                   rd_valid;
  logic                   rd_match;
  logic [TIME_W-1:0]      rd_age;
  logic                   rd_expired;
  logic                   rd_live;
  logic                   evict;
  logic [IDX_W-1:0]       tgt_idx;
  logic [CNT_IW-1:0]      new_count;
  logic                   hit;

  assign rd_valid   = slot_valid[idx];
  assign rd_match   = (slot_id[idx] == cur_id);
  assign rd_age     = cur_time - slot_time[idx];
  assign rd_expired = rd_valid && (rd_age > window_ticks);
  assign rd_live    = rd_valid && !rd_expired;

  assign evict     = !free_found;
  assign tgt_idx   = free_found ? free_idx : old_idx;
  assign new_count = surv_count + CNT_IW'(1) - CNT_IW'(evict && old_match);
  assign hit       = 32'(new_count) >= 32'(min_repeats);

  assign status.idx_last = (idx == IDX_W'(TABLE_DEPTH - 1));
  assign status.hit      = hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_repeats  <= MIN_W'(3);
      window_ticks <= TIME_W'(60);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_REPEATS:  min_repeats  <= cfg_data[MIN_W-1:0];
        REG_WINDOW_TICKS: window_ticks <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.age_step) begin
      if (rd_expired) slot_valid[idx] <= 1'b0;
    end else if (cmd.insert) begin
      slot_valid[tgt_idx] <= 1'b1;
    end else if (cmd.remove_step) begin
      if (rd_valid && rd_match) slot_valid[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      slot_id[tgt_idx]   <= cur_id;
      slot_time[tgt_idx] <= cur_time;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cur_id     <= device_id;
      cur_time   <= arrival_time;
      idx        <= '0;
      free_found <= 1'b0;
      old_found  <= 1'b0;
      surv_count <= '0;
    end else if (cmd.age_step) begin
      idx <= idx + IDX_W'(1);
      if (!rd_live && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
      if (rd_live && (!old_found || rd_age > old_age)) begin
        old_found <= 1'b1;
        old_idx   <= idx;
        old_age   <= rd_age;
        old_match <= rd_match;
      end
      if (rd_live && rd_match) surv_count <= surv_count + CNT_IW'(1);
    end else if (cmd.insert) begin
      idx       <= '0;
      res_count <= new_count;
      res_evict <= evict;
    end else if (cmd.remove_step) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      accepted       <= 32'(res_count) >= 32'(min_repeats);
      match_count    <= (32'(res_count) > 32'(CNT_MAX)) ? CNT_W'(CNT_MAX)
                                                        : CNT_W'(res_count);
      evicted_oldest <= res_evict;
    end
  end

endmodule

### rtl/wrqi_checker.sv
// ----------------------------------------------------------------------------
// wrqi_checker
// Port-level checks on the windowed repeat-ID qualifier.
// ----------------------------------------------------------------------------
module wrqi_checker
  import wrqi_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [ID_BITS-1:0]   device_id,
  input logic [TIME_W-1:0]    arrival_time,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 accepted,
  input logic [CNT_W-1:0]     match_count,
  input logic                 evicted_oldest
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in work");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |=>
      (in_valid && $stable(device_id) && $stable(arrival_time)))
    else $error("waiting request changed");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (match_count != '0))
    else $error("result without the current sighting counted");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(accepted) && $stable(match_count) && $stable(evicted_oldest)))
    else $error("stalled result changed");

endmodule

bind windowed_repeat_id_qualifier wrqi_checker u_wrqi_checker (.*);

### verif/windowed_repeat_id_qualifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_repeat_id_qualifier_tb
// Drives ID sightings with timestamps through the qualifier under random
// handshake gaps and stalls. A scoreboard tracks the slot table to predict
// each verdict (accepted, match count, eviction) and checks every result in
// order, across several window and repeat settings.
// ----------------------------------------------------------------------------
module windowed_repeat_id_qualifier_tb;
  import wrqi_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 150;
  localparam int NUM_PHASES  = 11;

  typedef struct packed {
    logic             accepted;
    logic [CNT_W-1:0] match_count;
    logic             evicted_oldest;
  } verdict_t;

  class sighting_tracker;
    bit                 live [TABLE_DEPTH];
    logic [ID_BITS-1:0] ids  [TABLE_DEPTH];
    logic [TIME_W-1:0]  seen [TABLE_DEPTH];
    logic [MIN_W-1:0]   min_rep;
    logic [TIME_W-1:0]  window;
    verdict_t           verdicts [$];
    int                 failures;

    function new();
      min_rep  = 5'd3;
      window   = 32'd60;
      failures = 0;
      foreach (live[i]) live[i] = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_MIN_REPEATS) min_rep = data[MIN_W-1:0];
      else if (idx == REG_WINDOW_TICKS) window = data[TIME_W-1:0];
    endfunction

    function void note_request(logic [ID_BITS-1:0] id, logic [TIME_W-1:0] t);
      int                free_idx;
      int                old_idx;
      logic [TIME_W-1:0] age;
      logic [TIME_W-1:0] old_age;
      int unsigned       hits;
      verdict_t          v;
      free_idx = -1;
      old_idx  = -1;
      old_age  = '0;
      hits     = 0;
      v        = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (live[i]) begin
          age = t - seen[i];
          if (age > window) live[i] = 1'b0;
          else if (old_idx < 0 || age > old_age) begin
            old_idx = i;
            old_age = age;
          end
        end
        if (!live[i] && free_idx < 0) free_idx = i;
      end
      if (free_idx < 0) begin
        free_idx = (old_idx < 0) ? 0 : old_idx;
        v.evicted_oldest = 1'b1;
      end
      live[free_idx] = 1'b1;
      ids[free_idx]  = id;
      seen[free_idx] = t;
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (live[i] && ids[i] == id && hits < CNT_MAX) hits++;
      v.match_count = hits[CNT_W-1:0];
      v.accepted    = (hits >= min_rep);
      // drop every sighting of an accepted ID
      if (v.accepted)
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (live[i] && ids[i] == id) live[i] = 1'b0;
      verdicts.insert(verdicts.size(), v);
    endfunction

    function void check_result(logic acc, logic [CNT_W-1:0] cnt, logic ev);
      verdict_t v;
      if (verdicts.size() == 0) begin
        $error("result with no request pending: accepted %0d, match_count %0d", acc, cnt);
        failures++;
        return;
      end
      v = verdicts.pop_front();
      if (acc !== v.accepted) begin
        $error("accepted: expected %0d, actual %0d", v.accepted, acc);
        failures++;
      end
      if (cnt !== v.match_count) begin
        $error("match_count: expected %0d, actual %0d", v.match_count, cnt);
        failures++;
      end
      if (ev !== v.evicted_oldest) begin
        $error("evicted_oldest: expected %0d, actual %0d", v.evicted_oldest, ev);
        failures++;
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [ID_BITS-1:0]   device_id;
  logic [TIME_W-1:0]    arrival_time;
  logic                 out_valid;
  logic                 out_ready;
  logic                 accepted;
  logic [CNT_W-1:0]     match_count;
  logic                 evicted_oldest;

  sighting_tracker tracker;
  bit              no_idle;
  int              cycles;

  windowed_repeat_id_qualifier dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .device_id      (device_id),
    .arrival_time   (arrival_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accepted       (accepted),
    .match_count    (match_count),
    .evicted_oldest (evicted_oldest)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_min_repeats(int unsigned m);
    logic [CFG_W-1:0] d;
    d = $urandom;
    d[MIN_W-1:0] = m[MIN_W-1:0];
    write_reg(REG_MIN_REPEATS, d);
  endtask

  task automatic send_request(logic [ID_BITS-1:0] id, logic [TIME_W-1:0] t);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    device_id    <= id;
    arrival_time <= t;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(id, t);
    @(negedge clk);
  endtask

  // hold off until every verdict is back
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // receive side
  initial begin
    int stall;
    out_ready <= 1'b0;
    do @(negedge clk); while (rst !== 1'b0);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      tracker.check_result(accepted, match_count, evicted_oldest);
      @(negedge clk);
    end
  end

  initial begin
    logic [TIME_W-1:0]  t;
    logic [TIME_W-1:0]  win;
    logic [ID_BITS-1:0] pool [24];
    logic [ID_BITS-1:0] id;
    int unsigned        mins [NUM_PHASES];
    logic [TIME_W-1:0]  wins [NUM_PHASES];
    int unsigned        pool_size;
    int unsigned        step_max;
    int unsigned        r;

    tracker      = new();
    cycles       = 0;
    no_idle      = 1'b0;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    device_id    <= '0;
    arrival_time <= '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: three sightings within 60 ticks
    send_request(32'h0000_0000, 32'd0);
    send_request(32'hFFFF_FFFF, 32'd0);
    send_request(32'h0000_0000, 32'd10);
    send_request(32'h0000_0000, 32'd20);
    send_request(32'hFFFF_FFFF, 32'd60);
    send_request(32'hFFFF_FFFF, 32'd121);
    send_request(32'hFFFF_FFFF, 32'd100);
    send_request(32'hA5A5_5A5A, 32'hFFFF_FFF0);
    send_request(32'hA5A5_5A5A, 32'h0000_0020);
    drain();

    // unreachable minimum and endless window: fill the table, then evict
    set_min_repeats(17);
    write_reg(REG_WINDOW_TICKS, 32'hFFFF_FFFF);
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_request(32'h1000_0000 + i * 32'h0101_0101, 32'd200 + i / 4);
    send_request(32'h5A5A_A5A5, 32'd300);
    send_request(32'h5A5A_A5A5, 32'd300);
    drain();

    mins = '{1, 3, 0, 2, 16, 17, 31, 4, 2, 6, $urandom_range(0, 31)};
    wins = '{32'd60, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd500, 32'd40, 32'hFFFF_FFFF,
             32'd100, 32'd20, $urandom, 32'd150};

    for (int p = 0; p < NUM_PHASES; p++) begin
      win = wins[p];
      set_min_repeats(mins[p]);
      write_reg(REG_WINDOW_TICKS, win);
      no_idle   = (p % 4 == 1);
      pool_size = (mins[p] >= 8 && mins[p] <= TABLE_DEPTH) ? $urandom_range(1, 2)
                                                           : $urandom_range(1, 24);
      foreach (pool[k]) pool[k] = $urandom;
      if (win <= 8) step_max = 2;
      else if (win > 32'd6000) step_max = 1000;
      else step_max = win / 6;
      t = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 5 && n == PHASE_ITEMS / 2) drain();
        r = $urandom_range(0, 99);
        if (r < 5) t = t - $urandom_range(1, 2000);
        else if (r < 8) t = t + $urandom;
        else t = t + $urandom_range(0, step_max);
        id = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_size - 1)];
        send_request(id, t);
      end
      drain();
    end

    no_idle = 1'b0;
    repeat (40) @(negedge clk);
    if (tracker.failures == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
